/* design/mtse_pkg.sv */
// Shared types and codes for the multitouch slot event translator.
// No dependencies.
`timescale 1ns / 1ps
package mtse_pkg;
	localparam int SLOT_COUNT_DEF = 16;

	localparam logic [3:0] OP_SLOT  = 4'd0;
	localparam logic [3:0] OP_TRKID = 4'd1;
	localparam logic [3:0] OP_X     = 4'd2;
	localparam logic [3:0] OP_Y     = 4'd3;
	localparam logic [3:0] OP_SHAPE = 4'd4;
	localparam logic [3:0] OP_SYNC  = 4'd5;
	localparam logic [3:0] OP_POS   = 4'd7;

	localparam logic [1:0] KIND_UP   = 2'd0;
	localparam logic [1:0] KIND_DOWN = 2'd1;
	localparam logic [1:0] KIND_MOVE = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_MAXX   = 3'd2;
	localparam logic [2:0] REG_MAXY   = 3'd3;
	localparam logic [2:0] REG_INVY   = 3'd4;

	// item passed from the front (decode/scale) to the back (slot table)
	typedef struct packed {
		logic [3:0]  opcode;
		logic [16:0] value;
		logic [11:0] coord;   // scaled and finished coordinate for X/Y
	} cmd_t;
endpackage

/* design/mtse_front.sv */
// Front part: accepts items, clamps and scales X/Y with a serial divider.
// Depends on mtse_pkg.
`timescale 1ns / 1ps
module mtse_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         in_opcode,
	input  logic [16:0]        in_value,
	input  logic [11:0]        disp_width,
	input  logic [11:0]        disp_height,
	input  logic [15:0]        raw_max_x,
	input  logic [15:0]        raw_max_y,
	input  logic               invert_y,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output mtse_pkg::cmd_t     cmd
);
	import mtse_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_DIV  = 3'b100
	} fstate_t;

	fstate_t     state_q;
	logic [3:0]  op_q;
	logic [16:0] val_q;
	logic [27:0] num_q;      // raw*size, then quotient bits shifted in
	logic [15:0] div_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [15:0] raw_c, max_c;
	logic [11:0] size_c;
	logic [16:0] trial;
	logic [11:0] q12, fin;
	logic        is_coord;

	assign is_coord = (in_opcode == OP_X) || (in_opcode == OP_Y);
	assign max_c  = (in_opcode == OP_X) ? raw_max_x : raw_max_y;
	assign size_c = (in_opcode == OP_X) ? disp_width : disp_height;
	always_comb begin
		if (in_value[16]) raw_c = '0;
		else if (in_value[15:0] > max_c) raw_c = max_c;
		else raw_c = in_value[15:0];
	end

	assign in_ready = (state_q == F_IDLE) && !done_q;
	// remainder stays below the divisor, so bit 16 of trial is the borrow
	assign trial = {rem_q, num_q[27]} - {1'b0, div_q};
	assign q12 = num_q[11:0];
	always_comb begin
		if (op_q == OP_X) fin = disp_width - q12;
		else if (invert_y) fin = disp_height - q12;
		else fin = q12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (done_q) begin
						if (cmd_ready) done_q <= 1'b0;
					end else if (in_valid) begin
						op_q  <= in_opcode;
						val_q <= is_coord ? {5'd0, size_c} : in_value;
						if (is_coord) begin
							num_q   <= {12'd0, raw_c};
							div_q   <= (max_c == 16'd0) ? 16'd1 : max_c;
							rem_q   <= '0;
							cnt_q   <= 5'd28;
							state_q <= F_MUL;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				F_MUL: begin
					// single 16x12 product, registered before the divider
					num_q   <= 28'(num_q[15:0] * val_q[11:0]);
					state_q <= F_DIV;
				end
				F_DIV: begin
					if (!trial[16]) begin
						rem_q <= trial[15:0];
						num_q <= {num_q[26:0], 1'b1};
					end else begin
						rem_q <= {rem_q[14:0], num_q[27]};
						num_q <= {num_q[26:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= F_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign cmd_valid = done_q;
	assign cmd.opcode = op_q;
	assign cmd.value  = val_q;
	assign cmd.coord  = fin;
endmodule

/* design/mtse_fifo.sv */
// Short queue between front and back parts.
// Depends on mtse_pkg.
`timescale 1ns / 1ps
module mtse_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  mtse_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output mtse_pkg::cmd_t rd_data
);
	import mtse_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wp_q == rp_q))
		else $error("queue pointers disagree when empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (wp_q == rp_q))
		else $error("queue pointers disagree when full");
endmodule

/* design/mtse_back.sv */
// Back part: slot table and event generation, zero, one or two results per item.
// Depends on mtse_pkg.
`timescale 1ns / 1ps
module mtse_back #(
	parameter int SLOT_COUNT = mtse_pkg::SLOT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  mtse_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_kind,
	output logic [11:0]    out_x,
	output logic [11:0]    out_y,
	output logic           out_last
);
	import mtse_pkg::*;
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [SW-1:0]   cur_q, fp_q;
	logic            fpv_q;
	logic [11:0]     sx_q [SLOT_COUNT];
	logic [11:0]     sy_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] rel_q, idc_q, pc_q;

	// two-entry result buffer: slot 0 shows, slot 1 waits
	logic [1:0]  ov_q;
	logic [26:0] ob_q [2];   // {kind,x,y,last}

	logic        take, rel_c, move_c;
	logic [SW-1:0] cs;

	assign cs = cur_q;
	assign cmd_ready = (ov_q == 2'b00);
	assign take = cmd_valid && cmd_ready;
	assign rel_c = (cmd.value == 17'h1FFFF);
	assign move_c = fpv_q && pc_q[fp_q];

	assign out_valid = ov_q[0];
	assign {out_kind, out_x, out_y, out_last} = ob_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			fp_q  <= '0;
			fpv_q <= 1'b0;
			rel_q <= '0;
			idc_q <= '0;
			pc_q  <= '0;
			ov_q  <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				sx_q[i] <= '0;
				sy_q[i] <= '0;
			end
		end else if (take) begin
			case (cmd.opcode)
				OP_SLOT: begin
					if (!cmd.value[16] && cmd.value < 17'(SLOT_COUNT))
						cur_q <= SW'(cmd.value);
				end
				OP_TRKID: begin
					rel_q[cs] <= rel_c;
					idc_q[cs] <= 1'b1;
					if (!fpv_q && !rel_c) begin
						fpv_q <= 1'b1;
						fp_q  <= cs;
					end else if (fpv_q && fp_q != cs && rel_c) begin
						fpv_q <= 1'b0;
					end
				end
				OP_X: begin
					if (sx_q[cs] != cmd.coord) begin
						sx_q[cs] <= cmd.coord;
						pc_q[cs] <= 1'b1;
					end
				end
				OP_Y: begin
					if (sy_q[cs] != cmd.coord) begin
						sy_q[cs] <= cmd.coord;
						pc_q[cs] <= 1'b1;
					end
				end
				OP_SHAPE: ;
				OP_SYNC: begin
					if (!(fpv_q && fp_q != cs) && idc_q[cs]) begin
						idc_q[cs] <= 1'b0;
						if (rel_q[cs]) begin
							fpv_q <= 1'b0;
							ov_q  <= 2'b01;
							ob_q[0] <= {KIND_UP, 24'd0, 1'b1};
						end else begin
							fpv_q <= 1'b1;
							fp_q  <= cs;
							if (move_c) begin
								pc_q[fp_q] <= 1'b0;
								ov_q <= 2'b11;
								ob_q[0] <= {KIND_MOVE, sx_q[fp_q], sy_q[fp_q], 1'b0};
								ob_q[1] <= {KIND_DOWN, 24'd0, 1'b1};
							end else begin
								ov_q <= 2'b01;
								ob_q[0] <= {KIND_DOWN, 24'd0, 1'b1};
							end
						end
					end
				end
				OP_POS: begin
					if (move_c) begin
						pc_q[fp_q] <= 1'b0;
						ov_q <= 2'b01;
						ob_q[0] <= {KIND_MOVE, sx_q[fp_q], sy_q[fp_q], 1'b1};
					end
				end
				default: begin
					ov_q <= 2'b01;
					ob_q[0] <= {KIND_ERR, 24'd0, 1'b1};
				end
			endcase
		end else if (ov_q[0] && out_ready) begin
			ov_q <= {1'b0, ov_q[1]};
			ob_q[0] <= ob_q[1];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ov_q[1] |-> ov_q[0])
		else $error("result buffer hole");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q == 2'b11) |-> !out_last)
		else $error("first of two results marked last");
endmodule

/* design/multitouch_slot_event_translator_top.sv */
// Path: an accepted item is registered in the front, passes the queue and is registered in
// the back's result buffer; X/Y items first pass one multiply and a 28-step restoring divider.
// The front takes no new item until it has handed the last one to the queue; the serial divider
// and stalled results can both hold it off. Front and back are joined by a two-entry
// queue. Reset (arst_n low, asynchronous) clears the slot table, registers to defaults, all queues.
// Depends on mtse_pkg, mtse_front, mtse_fifo, mtse_back.
`timescale 1ns / 1ps
module multitouch_slot_event_translator_top #(
	parameter int SLOT_COUNT = mtse_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [3:0] opcode, [20:4] event_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [1:0] event_kind, [13:2] pos_x, [25:14] pos_y
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mtse_pkg::*;

	logic [11:0] width_q, height_q;
	logic [15:0] maxx_q, maxy_q;
	logic        invy_q;
	logic        f_valid, f_ready, b_valid, b_ready;
	cmd_t        f_cmd, b_cmd;
	logic [1:0]  kind;
	logic [11:0] px, py;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd1024;
			height_q <= 12'd768;
			maxx_q   <= 16'hFFFF;
			maxy_q   <= 16'hFFFF;
			invy_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[11:0];
				REG_HEIGHT: height_q <= cfg_data[11:0];
				REG_MAXX:   maxx_q   <= cfg_data;
				REG_MAXY:   maxy_q   <= cfg_data;
				REG_INVY:   invy_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mtse_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_opcode(s_axis_tdata[3:0]), .in_value(s_axis_tdata[20:4]),
		.disp_width(width_q), .disp_height(height_q),
		.raw_max_x(maxx_q), .raw_max_y(maxy_q), .invert_y(invy_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	mtse_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	mtse_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(kind), .out_x(px), .out_y(py), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, py, px, kind};
endmodule
